// ----- hdl/dnss_pkg.sv -----
// Shared types and constants for the DNS message section splitter.
package dnss_pkg;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_QNAME    = 3'd1,
        PH_QTAIL    = 3'd2,
        PH_AFIXED   = 3'd3,
        PH_ADATA    = 3'd4,
        PH_AUTH     = 3'd5,
        PH_UNPARSED = 3'd6
    } phase_t;

    localparam logic [3:0]  HEADER_LEN       = 4'd12;
    localparam logic [15:0] ANSWER_FIXED_LEN = 16'd12;
    localparam logic [15:0] QUERY_TAIL_LEN   = 16'd4;
    localparam logic [15:0] LENGTH_LOW_MARK  = 16'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  section;
        logic        record_start;
        logic [15:0] answer_index;
        logic [15:0] transaction_id;
        logic [15:0] flag_bits;
        logic [15:0] question_count;
        logic [15:0] answer_count;
        logic [15:0] authority_count;
        logic [15:0] additional_count;
        logic        header_complete;
        logic        packet_end;
    } result_item_t;

endpackage

// ----- hdl/dnss_parser.sv -----
// Parse state and per-byte section tagging logic.
module dnss_parser
    import dnss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  byte_item_t   item,
    output result_item_t result
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  header_offset_reg, header_offset_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] answers_left_reg, answers_left_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] answer_number_reg, answer_number_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] flags_reg, flags_next;
    logic [15:0] question_reg, question_next;
    logic [15:0] answer_reg, answer_next;
    logic [15:0] authority_reg, authority_next;
    logic [15:0] additional_reg, additional_next;
    logic        first_reg, first_next;

    logic [2:0]  sec;
    logic        start;
    logic [15:0] idx;
    logic [3:0]  offset_inc;
    logic [15:0] bytes_dec;
    logic [15:0] answers_dec;
    logic [15:0] data_len;
    logic [7:0]  b;

    always_comb
    begin
        b                  = item.data_byte;
        phase_next         = phase_reg;
        header_offset_next = header_offset_reg;
        bytes_left_next    = bytes_left_reg;
        answers_left_next  = answers_left_reg;
        length_high_next   = length_high_reg;
        answer_number_next = answer_number_reg;
        id_next            = id_reg;
        flags_next         = flags_reg;
        question_next      = question_reg;
        answer_next        = answer_reg;
        authority_next     = authority_reg;
        additional_next    = additional_reg;
        first_next         = first_reg;
        sec                = PH_UNPARSED;
        start              = first_reg;
        idx                = '0;
        offset_inc         = header_offset_reg + 4'd1;
        bytes_dec          = bytes_left_reg - 16'd1;
        answers_dec        = answers_left_reg - 16'd1;
        data_len           = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                sec   = PH_HEADER;
                start = (header_offset_reg == 4'd0);
                unique case (header_offset_reg[3:1])
                    3'd0:    id_next         = {id_reg[7:0], b};
                    3'd1:    flags_next      = {flags_reg[7:0], b};
                    3'd2:    question_next   = {question_reg[7:0], b};
                    3'd3:    answer_next     = {answer_reg[7:0], b};
                    3'd4:    authority_next  = {authority_reg[7:0], b};
                    default: additional_next = {additional_reg[7:0], b};
                endcase
                header_offset_next = offset_inc;
                first_next         = 1'b0;
                if (offset_inc >= HEADER_LEN)
                begin
                    header_offset_next = HEADER_LEN;
                    first_next         = 1'b1;
                    if (question_next != 16'd0)
                    begin
                        phase_next      = PH_QNAME;
                        bytes_left_next = '0;
                    end
                    else if (answer_next != 16'd0)
                    begin
                        phase_next         = PH_AFIXED;
                        answers_left_next  = answer_next;
                        answer_number_next = '0;
                        bytes_left_next    = ANSWER_FIXED_LEN;
                    end
                    else
                    begin
                        phase_next = (authority_next != 16'd0) ? PH_AUTH : PH_UNPARSED;
                    end
                end
            end
            PH_QNAME:
            begin
                sec        = PH_QNAME;
                first_next = 1'b0;
                if (bytes_left_reg == 16'd0)
                begin
                    if (b == 8'd0)
                    begin
                        phase_next      = PH_QTAIL;
                        bytes_left_next = QUERY_TAIL_LEN;
                        first_next      = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = {8'd0, b};
                    end
                end
                else
                begin
                    bytes_left_next = bytes_dec;
                end
            end
            PH_QTAIL:
            begin
                sec             = PH_QTAIL;
                first_next      = 1'b0;
                bytes_left_next = bytes_dec;
                if (bytes_dec == 16'd0)
                begin
                    first_next = 1'b1;
                    if (answer_reg != 16'd0)
                    begin
                        phase_next         = PH_AFIXED;
                        answers_left_next  = answer_reg;
                        answer_number_next = '0;
                        bytes_left_next    = ANSWER_FIXED_LEN;
                    end
                    else
                    begin
                        phase_next = (authority_reg != 16'd0) ? PH_AUTH : PH_UNPARSED;
                    end
                end
            end
            PH_AFIXED, PH_ADATA:
            begin
                sec        = (phase_reg == PH_AFIXED) ? PH_AFIXED : PH_ADATA;
                idx        = answer_number_reg;
                first_next = 1'b0;
                if (phase_reg == PH_AFIXED && bytes_left_reg == LENGTH_LOW_MARK)
                    length_high_next = b;
                bytes_left_next = bytes_dec;
                data_len        = {length_high_next, b};
                if (bytes_dec == 16'd0)
                begin
                    first_next = 1'b1;
                    if (phase_reg == PH_AFIXED && data_len != 16'd0)
                    begin
                        // Fixed part done: move on to the record data.
                        phase_next      = PH_ADATA;
                        bytes_left_next = data_len;
                    end
                    else
                    begin
                        // Record done: advance to the next answer or leave.
                        answer_number_next = answer_number_reg + 16'd1;
                        answers_left_next  = answers_dec;
                        if (answers_dec != 16'd0)
                        begin
                            phase_next      = PH_AFIXED;
                            bytes_left_next = ANSWER_FIXED_LEN;
                        end
                        else
                        begin
                            phase_next = (authority_reg != 16'd0) ? PH_AUTH : PH_UNPARSED;
                        end
                    end
                end
            end
            PH_AUTH:
            begin
                sec        = PH_AUTH;
                first_next = 1'b0;
            end
            default:
            begin
                sec        = PH_UNPARSED;
                first_next = 1'b0;
            end
        endcase

        result.section          = sec;
        result.record_start     = start;
        result.answer_index     = idx;
        result.transaction_id   = id_next;
        result.flag_bits        = flags_next;
        result.question_count   = question_next;
        result.answer_count     = answer_next;
        result.authority_count  = authority_next;
        result.additional_count = additional_next;
        result.header_complete  = (header_offset_next >= HEADER_LEN);
        result.packet_end       = item.end_of_packet;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            header_offset_reg <= '0;
            bytes_left_reg    <= '0;
            answers_left_reg  <= '0;
            length_high_reg   <= '0;
            answer_number_reg <= '0;
            id_reg            <= '0;
            flags_reg         <= '0;
            question_reg      <= '0;
            answer_reg        <= '0;
            authority_reg     <= '0;
            additional_reg    <= '0;
            first_reg         <= 1'b1;
        end
        else if (accept)
        begin
            if (item.end_of_packet)
            begin
                // Last byte: drop all parse state back to the header phase.
                phase_reg         <= PH_HEADER;
                header_offset_reg <= '0;
                bytes_left_reg    <= '0;
                answers_left_reg  <= '0;
                length_high_reg   <= '0;
                answer_number_reg <= '0;
                id_reg            <= '0;
                flags_reg         <= '0;
                question_reg      <= '0;
                answer_reg        <= '0;
                authority_reg     <= '0;
                additional_reg    <= '0;
                first_reg         <= 1'b1;
            end
            else
            begin
                phase_reg         <= phase_next;
                header_offset_reg <= header_offset_next;
                bytes_left_reg    <= bytes_left_next;
                answers_left_reg  <= answers_left_next;
                length_high_reg   <= length_high_next;
                answer_number_reg <= answer_number_next;
                id_reg            <= id_next;
                flags_reg         <= flags_next;
                question_reg      <= question_next;
                answer_reg        <= answer_next;
                authority_reg     <= authority_next;
                additional_reg    <= additional_next;
                first_reg         <= first_next;
            end
        end
    end

    a_header_offset_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (header_offset_reg < HEADER_LEN))
        else $error("header offset out of range in header phase");

    a_header_done_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_HEADER) |-> (header_offset_reg == HEADER_LEN))
        else $error("left header phase before twelve bytes");

    a_answers_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_AFIXED || phase_reg == PH_ADATA) |-> (answers_left_reg != 16'd0))
        else $error("answer phase with no answers left");

    a_fixed_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_AFIXED) |-> (bytes_left_reg != 16'd0 &&
                                      bytes_left_reg <= ANSWER_FIXED_LEN))
        else $error("answer fixed part count out of range");

endmodule

// ----- hdl/dnss_skid.sv -----
// Output register with one skid entry for the result channel.
module dnss_skid
    import dnss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  result_item_t push_item,
    output logic         full,
    output logic         out_valid,
    input  logic         out_stall,
    output result_item_t out_item
);

    logic         main_valid_reg;
    logic         skid_valid_reg;
    result_item_t main_reg;
    result_item_t skid_reg;
    logic         main_free;

    assign main_free = !main_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            // Refill the output from the skid entry first, else from the parser.
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
            main_reg <= skid_valid_reg ? skid_reg : push_item;
        else if (push)
            skid_reg <= push_item;
    end

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while output register empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("transaction pushed into full skid stage");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && out_stall && push))
        else $error("skid entry filled without a stalled output");

endmodule

// ----- hdl/dns_message_section_splitter.sv -----
// Top level of the DNS message section splitter.
//
//   channel   direction  handshake                    payload
//   byte      in         byte_valid / byte_stall      byte_item   (byte_item_t)
//   result    out        result_valid / result_stall  result_item (result_item_t)
//
// One transaction in gives one transaction out, registered at acceptance.
// With byte_stall low a byte is taken every cycle, updating the parse state.
// Reset (rst_n low) returns the parse to the header phase with all captured
// words zero; a byte with end_of_packet does the same after its result.
// When result_stall holds, one more result lands in the skid entry, after
// which byte_stall rises until the receiver takes the waiting result.
module dns_message_section_splitter
    import dnss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_stall,
    input  byte_item_t   byte_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    logic         byte_accept;
    logic         skid_full;
    result_item_t parsed;

    // Stall the input only while the skid entry is occupied.
    assign byte_stall  = skid_full;
    assign byte_accept = byte_valid && !skid_full;

    dnss_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (byte_accept),
        .item   (byte_item),
        .result (parsed)
    );

    dnss_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (byte_accept),
        .push_item (parsed),
        .full      (skid_full),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_item  (result_item)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the DNS message section splitter.
module testbench
    import dnss_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Random part length in message bytes, idle limit, and cycles to wait
    // once nothing is outstanding.
    localparam int RANDOM_BYTES = 600;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {
        STALL_NONE,
        STALL_SPRINKLED,
        STALL_BLOCKS
    } stall_mode_t;

    typedef enum int {
        MSG_WELL_FORMED,
        MSG_TRUNCATED,
        MSG_NOISE
    } message_kind_t;

    // Tracks the parse of the byte stream and holds the section tag that
    // each accepted byte must come back with.
    class section_scoreboard;
        logic [3:0]   header_offset;
        phase_t       phase;
        logic [15:0]  bytes_left;
        logic [15:0]  answers_left;
        logic [7:0]   length_high;
        logic [15:0]  answer_number;
        logic [15:0]  header_word [6];
        logic         first_of_section;
        result_item_t expected_tags [$];
        int           errors;

        function new();
            errors = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            header_offset    = '0;
            phase            = PH_HEADER;
            bytes_left       = '0;
            answers_left     = '0;
            length_high      = '0;
            answer_number    = '0;
            foreach (header_word[i])
                header_word[i] = '0;
            first_of_section = 1'b1;
        endfunction

        function int pending();
            return expected_tags.size();
        endfunction

        // Everything after the answers is authority or unparsed.
        function void enter_trailer();
            phase            = (header_word[4] != 16'd0) ? PH_AUTH : PH_UNPARSED;
            first_of_section = 1'b1;
        endfunction

        function void enter_answers();
            if (header_word[3] != 16'd0)
            begin
                phase            = PH_AFIXED;
                answers_left     = header_word[3];
                answer_number    = '0;
                bytes_left       = ANSWER_FIXED_LEN;
                first_of_section = 1'b1;
            end
            else
                enter_trailer();
        endfunction

        function void close_answer();
            answer_number = answer_number + 16'd1;
            answers_left  = answers_left - 16'd1;
            if (answers_left != 16'd0)
            begin
                phase            = PH_AFIXED;
                bytes_left       = ANSWER_FIXED_LEN;
                first_of_section = 1'b1;
            end
            else
                enter_trailer();
        endfunction

        // Tag one accepted byte, advance the parse and queue the tag.
        function void note_byte(byte_item_t item);
            result_item_t tag;
            logic [15:0]  data_len;
            int           word_sel;
            tag              = '0;
            tag.section      = PH_UNPARSED;
            tag.record_start = first_of_section;
            case (phase)
                PH_HEADER:
                begin
                    tag.section      = PH_HEADER;
                    tag.record_start = (header_offset == 4'd0);
                    word_sel         = int'(header_offset >> 1);
                    header_word[word_sel] = {header_word[word_sel][7:0], item.data_byte};
                    header_offset    = header_offset + 4'd1;
                    if (header_offset >= HEADER_LEN)
                    begin
                        header_offset = HEADER_LEN;
                        if (header_word[2] != 16'd0)
                        begin
                            phase            = PH_QNAME;
                            bytes_left       = '0;
                            first_of_section = 1'b1;
                        end
                        else
                            enter_answers();
                    end
                    else
                        first_of_section = 1'b0;
                end
                PH_QNAME:
                begin
                    tag.section      = PH_QNAME;
                    first_of_section = 1'b0;
                    if (bytes_left == 16'd0)
                    begin
                        if (item.data_byte == 8'd0)
                        begin
                            phase            = PH_QTAIL;
                            bytes_left       = QUERY_TAIL_LEN;
                            first_of_section = 1'b1;
                        end
                        else
                            bytes_left = {8'd0, item.data_byte};
                    end
                    else
                        bytes_left = bytes_left - 16'd1;
                end
                PH_QTAIL:
                begin
                    tag.section      = PH_QTAIL;
                    first_of_section = 1'b0;
                    bytes_left       = bytes_left - 16'd1;
                    if (bytes_left == 16'd0)
                        enter_answers();
                end
                PH_AFIXED:
                begin
                    tag.section      = PH_AFIXED;
                    tag.answer_index = answer_number;
                    first_of_section = 1'b0;
                    if (bytes_left == LENGTH_LOW_MARK)
                        length_high = item.data_byte;
                    bytes_left = bytes_left - 16'd1;
                    if (bytes_left == 16'd0)
                    begin
                        data_len = {length_high, item.data_byte};
                        if (data_len != 16'd0)
                        begin
                            phase            = PH_ADATA;
                            bytes_left       = data_len;
                            first_of_section = 1'b1;
                        end
                        else
                            close_answer();
                    end
                end
                PH_ADATA:
                begin
                    tag.section      = PH_ADATA;
                    tag.answer_index = answer_number;
                    first_of_section = 1'b0;
                    bytes_left       = bytes_left - 16'd1;
                    if (bytes_left == 16'd0)
                        close_answer();
                end
                PH_AUTH:
                begin
                    tag.section      = PH_AUTH;
                    first_of_section = 1'b0;
                end
                default:
                begin
                    tag.section      = PH_UNPARSED;
                    first_of_section = 1'b0;
                end
            endcase
            tag.transaction_id   = header_word[0];
            tag.flag_bits        = header_word[1];
            tag.question_count   = header_word[2];
            tag.answer_count     = header_word[3];
            tag.authority_count  = header_word[4];
            tag.additional_count = header_word[5];
            tag.header_complete  = (header_offset >= HEADER_LEN);
            tag.packet_end       = item.end_of_packet;
            expected_tags.insert(expected_tags.size(), tag);
            if (item.end_of_packet)
                clear_parse();
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_item_t got);
            result_item_t want;
            if (expected_tags.size() == 0)
            begin
                $error("result with no byte waiting for it (section %0d)", got.section);
                errors++;
                return;
            end
            want = expected_tags.pop_front();
            compare_field("section", 16'(want.section), 16'(got.section));
            compare_field("record_start", 16'(want.record_start), 16'(got.record_start));
            compare_field("answer_index", want.answer_index, got.answer_index);
            compare_field("transaction_id", want.transaction_id, got.transaction_id);
            compare_field("flag_bits", want.flag_bits, got.flag_bits);
            compare_field("question_count", want.question_count, got.question_count);
            compare_field("answer_count", want.answer_count, got.answer_count);
            compare_field("authority_count", want.authority_count, got.authority_count);
            compare_field("additional_count", want.additional_count, got.additional_count);
            compare_field("header_complete", 16'(want.header_complete),
                          16'(got.header_complete));
            compare_field("packet_end", 16'(want.packet_end), 16'(got.packet_end));
        endfunction
    endclass

    // Every input is known from time zero.
    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         byte_valid   = 1'b0;
    logic         byte_stall;
    byte_item_t   byte_item    = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_item_t result_item;

    section_scoreboard sb = new();

    logic [7:0]  packet_bytes [$];
    int          bytes_sent    = 0;
    int          burst_left    = 0;
    bit          sender_idles  = 1'b1;
    stall_mode_t stall_mode    = STALL_NONE;
    int          stall_run     = 0;
    int          quiet_cycles  = 0;

    dns_message_section_splitter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Watch both channels at every edge. Note the input transaction first so
    // that a result landing on the same edge still finds its expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                sb.note_byte(byte_item);
            if (result_valid && !result_stall)
                sb.check_result(result_item);
        end
        if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Receiver back-pressure: none, stalls scattered at random, or runs of
    // back-to-back stalls.
    always @(posedge clk)
    begin
        case (stall_mode)
            STALL_NONE:
                result_stall <= 1'b0;
            STALL_SPRINKLED:
                result_stall <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (stall_run > 0)
                begin
                    stall_run--;
                    result_stall <= 1'b1;
                end
                else
                begin
                    result_stall <= 1'b0;
                    if ($urandom_range(0, 7) == 0)
                        stall_run = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // Abort when neither channel moves a transaction for too long.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // Present one byte and hold it until it is taken. Between bursts of
    // random length, drop valid for a random gap when idling is enabled.
    task automatic send_byte(input logic [7:0] data, input logic last);
        byte_item_t item;
        item.data_byte     = data;
        item.end_of_packet = last;
        if (burst_left == 0)
        begin
            if (sender_idles)
            begin
                byte_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        byte_valid <= 1'b1;
        byte_item  <= item;
        do
        begin
            @(posedge clk);
        end
        while (byte_stall);
        bytes_sent++;
    endtask

    // Send the built message with end_of_packet on its last byte.
    task automatic send_packet();
        foreach (packet_bytes[i])
            send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
    endtask

    // Drop valid and hold off until every queued tag has come back.
    task automatic drain_results();
        byte_valid <= 1'b0;
        burst_left = 0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
    endtask

    function void add_byte(logic [7:0] value);
        packet_bytes.insert(packet_bytes.size(), value);
    endfunction

    function void push_word(logic [15:0] w);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endfunction

    function void push_random(int count);
        repeat (count) add_byte(8'($urandom_range(0, 255)));
    endfunction

    // Build a message that walks the whole parse: header, at most one query, a few
    // answers, then trailing bytes. Counts and lengths now and then claim
    // more than is really sent, so the parse runs past or is cut by the end.
    function void build_message();
        logic [15:0] question_word;
        logic [15:0] answer_word;
        logic [15:0] length_word;
        int          answer_records;
        int          label_len;
        int          data_len;
        packet_bytes.delete();
        case ($urandom_range(0, 5))
            0:       question_word = 16'd0;
            1:       question_word = 16'($urandom_range(2, 65535));
            default: question_word = 16'd1;
        endcase
        answer_records = $urandom_range(0, 3);
        answer_word    = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'(answer_records);
        push_word(16'($urandom_range(0, 65535)));
        push_word(16'($urandom_range(0, 65535)));
        push_word(question_word);
        push_word(answer_word);
        push_word(($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535)) : 16'd0);
        push_word(16'($urandom_range(0, 65535)));
        if (question_word != 16'd0)
        begin
            repeat ($urandom_range(0, 3))
            begin
                label_len = $urandom_range(1, 6);
                add_byte(8'(label_len));
                push_random(label_len);
            end
            add_byte(8'd0);
            push_random(4);
        end
        repeat (answer_records)
        begin
            data_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            length_word = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'(data_len);
            push_random(10);
            push_word(length_word);
            push_random(data_len);
        end
        push_random($urandom_range(0, 4));
    endfunction

    initial
    begin
        message_kind_t kind;
        int            cut;
        bit            paused;
        paused = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a message cut after its first byte, then one with extreme
        // header words, an empty-data answer and an authority byte at the end.
        packet_bytes.delete();
        add_byte(8'hFF);
        send_packet();
        packet_bytes.delete();
        push_word(16'hFFFF);
        push_word(16'h0000);
        push_word(16'h0000);
        push_word(16'h0001);
        push_word(16'hFFFF);
        push_word(16'hFFFF);
        push_random(10);
        push_word(16'h0000);
        add_byte(8'h5A);
        send_packet();

        // Random: mostly well-formed messages with random content, the rest
        // cut short or pure noise. Vary idling on both sides per message.
        while (bytes_sent < RANDOM_BYTES)
        begin
            sender_idles = ($urandom_range(0, 3) != 0);
            stall_mode   = stall_mode_t'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
                0, 1:    kind = MSG_TRUNCATED;
                2:       kind = MSG_NOISE;
                default: kind = MSG_WELL_FORMED;
            endcase
            if (kind == MSG_NOISE)
            begin
                packet_bytes.delete();
                push_random($urandom_range(1, 16));
            end
            else
            begin
                build_message();
                if (kind == MSG_TRUNCATED)
                begin
                    cut = int'($urandom_range(1, packet_bytes.size()));
                    while (packet_bytes.size() > cut)
                        void'(packet_bytes.pop_back());
                end
            end
            send_packet();
            if (!paused && bytes_sent >= RANDOM_BYTES / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
